// File: src/trace_column_span_rasterizer_top_macros.svh
// ----------------------------------------------------------------------------
// Trace column span rasterizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRACE_COLUMN_SPAN_RASTERIZER_TOP_MACROS_SVH
`define TRACE_COLUMN_SPAN_RASTERIZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCSR_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCSR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace column span rasterizer package
// Widths, register indexes, stage payload types and the coordinate mapping.
// ----------------------------------------------------------------------------
package tcsr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 16;

  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int OUT_W     = 16;
  localparam int COUNT_W   = 16;
  localparam int COLOR_W   = 24;
  localparam int MARGIN_W  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int SPAN_STEP = 2;

  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POINTS = CFG_IDX_W'(5);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  localparam coord_t COORD_MAX   = coord_t'((2 ** (COORD_BITS - 1)) - 1);
  localparam coord_t COORD_MIN   = coord_t'(-(2 ** (COORD_BITS - 1)));
  localparam prod_t  COORD_MAX_P = prod_t'((2 ** (COORD_BITS - 1)) - 1);
  localparam prod_t  COORD_MIN_P = prod_t'(-(2 ** (COORD_BITS - 1)));

  typedef struct packed {
    logic signed [DATA_W-1:0] y_offset;
    logic [DATA_W-1:0]        y_scale;
    logic signed [DATA_W-1:0] x_offset;
    logic [DATA_W-1:0]        x_scale;
    logic [MARGIN_W-1:0]      margin;
    logic [COUNT_W-1:0]       max_points;
  } cfg_t;

  typedef struct packed {
    logic                first;
    logic                over;
    diff_t               dx;
    diff_t               dy;
    logic [COLOR_W-1:0]  color;
  } s1_t;

  typedef struct packed {
    logic                first;
    logic                over;
    prod_t               px;
    prod_t               py;
    logic [COLOR_W-1:0]  color;
  } s2_t;

  // Floors a fixed-point product to an integer coordinate and saturates it.
  function automatic coord_t map_floor(prod_t p);
    prod_t q;
    q = p >>> FRAC_BITS;
    if (q > COORD_MAX_P) begin
      return COORD_MAX;
    end else if (q < COORD_MIN_P) begin
      return COORD_MIN;
    end
    return coord_t'(q);
  endfunction

endpackage

// File: src/tcsr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace column span rasterizer configuration registers
// Holds the axis offsets, scales, margin and point limit.
// ----------------------------------------------------------------------------
module tcsr_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcsr_pkg::DATA_W-1:0]         cfg_data,
  output tcsr_pkg::cfg_t                      cfg_o
);
  import tcsr_pkg::*;

  localparam logic [DATA_W-1:0] SCALE_ONE = DATA_W'(2 ** FRAC_BITS);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_Y_OFFSET:   cfg_nxt.y_offset   = cfg_data;
        REG_Y_SCALE:    cfg_nxt.y_scale    = cfg_data;
        REG_X_OFFSET:   cfg_nxt.x_offset   = cfg_data;
        REG_X_SCALE:    cfg_nxt.x_scale    = cfg_data;
        REG_MARGIN:     cfg_nxt.margin     = cfg_data[MARGIN_W-1:0];
        REG_MAX_POINTS: cfg_nxt.max_points = cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.y_offset   <= '0;
      cfg_r.y_scale    <= SCALE_ONE;
      cfg_r.x_offset   <= '0;
      cfg_r.x_scale    <= SCALE_ONE;
      cfg_r.margin     <= '0;
      cfg_r.max_points <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/tcsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace column span rasterizer input stage
// Registers each sample with its offset removed and its point limit checked.
// ----------------------------------------------------------------------------
module tcsr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcsr_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_first,
  input  logic signed [tcsr_pkg::DATA_W-1:0]  in_x_sample,
  input  logic signed [tcsr_pkg::DATA_W-1:0]  in_y_sample,
  input  logic [tcsr_pkg::COUNT_W-1:0]        in_point_count,
  input  logic [tcsr_pkg::COLOR_W-1:0]        in_color,
  output logic                                s1_valid_o,
  output tcsr_pkg::s1_t                       s1_o,
  input  logic                                s1_ready_i
);
  import tcsr_pkg::*;

  logic valid_r;
  s1_t  s1_r;
  s1_t  s1_nxt;

  assign in_ready   = !valid_r | s1_ready_i;
  assign s1_valid_o = valid_r;
  assign s1_o       = s1_r;

  always_comb begin
    s1_nxt.first = in_first;
    s1_nxt.over  = in_point_count > cfg_i.max_points;
    s1_nxt.dx    = DIFF_W'(in_x_sample) - DIFF_W'(cfg_i.x_offset);
    s1_nxt.dy    = DIFF_W'(in_y_sample) - DIFF_W'(cfg_i.y_offset);
    s1_nxt.color = in_color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// File: src/tcsr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace column span rasterizer scaling stage
// Multiplies the x and y offsets by their axis scales and registers both products.
// ----------------------------------------------------------------------------
module tcsr_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  tcsr_pkg::cfg_t    cfg_i,
  input  logic              s1_valid_i,
  input  tcsr_pkg::s1_t     s1_i,
  output logic              s1_ready_o,
  output logic              s2_valid_o,
  output tcsr_pkg::s2_t     s2_o,
  input  logic              s2_ready_i
);
  import tcsr_pkg::*;

  logic valid_r;
  s2_t  s2_r;
  s2_t  s2_nxt;

  assign s1_ready_o = !valid_r | s2_ready_i;
  assign s2_valid_o = valid_r;
  assign s2_o       = s2_r;

  always_comb begin
    s2_nxt.first = s1_i.first;
    s2_nxt.over  = s1_i.over;
    s2_nxt.px    = s1_i.dx * $signed({1'b0, cfg_i.x_scale});
    s2_nxt.py    = s1_i.dy * $signed({1'b0, cfg_i.y_scale});
    s2_nxt.color = s1_i.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready_o) begin
      valid_r <= s1_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_i && s1_ready_o) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

// File: src/tcsr_span.sv
`timescale 1ns / 1ps
`include "trace_column_span_rasterizer_top_macros.svh"
// ----------------------------------------------------------------------------
// Trace column span rasterizer span stage
// Floors and saturates rows and columns, joins each row to the previous one
// and holds the trace state and the result register.
// ----------------------------------------------------------------------------
module tcsr_span (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcsr_pkg::cfg_t                      cfg_i,
  input  logic                                s2_valid_i,
  input  tcsr_pkg::s2_t                       s2_i,
  output logic                                s2_ready_o,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tcsr_pkg::OUT_W-1:0]   out_column,
  output logic signed [tcsr_pkg::OUT_W-1:0]   out_row_low,
  output logic signed [tcsr_pkg::OUT_W-1:0]   out_row_high,
  output logic [tcsr_pkg::COLOR_W-1:0]        out_paint_color,
  output logic                                out_error
);
  import tcsr_pkg::*;

  localparam int SUM_W = COORD_BITS + 2;
  localparam int DIF_W = COORD_BITS + 1;

  logic   valid_r;
  coord_t prev_row_r;
  coord_t prev_row_nxt;
  coord_t col_r;
  coord_t col_nxt;
  logic   rej_r;
  logic   rej_nxt;

  logic signed [OUT_W-1:0] out_col_r;
  logic signed [OUT_W-1:0] out_col_nxt;
  logic signed [OUT_W-1:0] out_lo_r;
  logic signed [OUT_W-1:0] out_lo_nxt;
  logic signed [OUT_W-1:0] out_hi_r;
  logic signed [OUT_W-1:0] out_hi_nxt;
  logic [COLOR_W-1:0]      out_color_r;
  logic [COLOR_W-1:0]      out_color_nxt;
  logic                    out_err_r;

  coord_t                  row;
  coord_t                  map_col;
  coord_t                  lo;
  coord_t                  hi;
  logic signed [SUM_W-1:0] col_sum;
  logic signed [DIF_W-1:0] row_step;
  logic                    load;
  logic                    reject;

  assign s2_ready_o      = !valid_r | out_ready;
  assign load            = s2_valid_i & s2_ready_o;
  assign out_valid       = valid_r;
  assign out_column      = out_col_r;
  assign out_row_low     = out_lo_r;
  assign out_row_high    = out_hi_r;
  assign out_paint_color = out_color_r;
  assign out_error       = out_err_r;

  always_comb begin
    row          = map_floor(s2_i.py);
    map_col      = map_floor(s2_i.px);
    col_sum      = SUM_W'(map_col) + $signed(SUM_W'(cfg_i.margin));
    row_step     = DIF_W'(row) - DIF_W'(prev_row_r);
    reject       = s2_i.first ? s2_i.over : rej_r;
    rej_nxt      = reject;
    prev_row_nxt = prev_row_r;
    col_nxt      = col_r;
    lo           = row;
    hi           = row;
    if (!reject) begin
      prev_row_nxt = row;
      if (s2_i.first) begin
        if (col_sum > SUM_W'(COORD_MAX)) begin
          col_nxt = COORD_MAX;
        end else begin
          col_nxt = coord_t'(col_sum);
        end
      end else begin
        if (col_r != COORD_MAX) begin
          col_nxt = col_r + coord_t'(1);
        end
        if (row_step >= DIF_W'(SPAN_STEP)) begin
          lo = prev_row_r + coord_t'(1);
        end else if (row_step <= -DIF_W'(SPAN_STEP)) begin
          hi = prev_row_r - coord_t'(1);
        end
      end
    end
    out_col_nxt   = reject ? '0 : OUT_W'(col_nxt);
    out_lo_nxt    = reject ? '0 : OUT_W'(lo);
    out_hi_nxt    = reject ? '0 : OUT_W'(hi);
    out_color_nxt = reject ? '0 : s2_i.color;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      prev_row_r <= '0;
      col_r      <= '0;
      rej_r      <= 1'b0;
    end else begin
      if (s2_ready_o) begin
        valid_r <= s2_valid_i;
      end
      if (load) begin
        prev_row_r <= prev_row_nxt;
        col_r      <= col_nxt;
        rej_r      <= rej_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_col_r   <= out_col_nxt;
      out_lo_r    <= out_lo_nxt;
      out_hi_r    <= out_hi_nxt;
      out_color_r <= out_color_nxt;
      out_err_r   <= reject;
    end
  end

  `TCSR_ASSERT_IMPLY(a_error_blank, out_valid && out_error, out_column == '0 && out_row_low == '0 && out_row_high == '0 && out_paint_color == '0, "Rejected result carries paint data.")
  `TCSR_ASSERT_IMPLY(a_span_order, out_valid && !out_error, out_row_low <= out_row_high, "Span low row is above its high row.")
  `TCSR_ASSERT_NEXT(a_prev_row_end, load && !reject, OUT_W'(prev_row_r) == out_row_low || OUT_W'(prev_row_r) == out_row_high, "Stored row is not an end of the span.")
  `TCSR_ASSERT_NEXT(a_reject_held, load && reject, rej_r && out_error, "Rejected trace state not held.")

endmodule

// File: src/trace_column_span_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace column span rasterizer
// Maps trace samples to a pixel column and a gap-free vertical span of rows.
// ----------------------------------------------------------------------------
// A sample accepted at the input passes, in order, an input register that
// removes the axis offsets, a register after the two 33 by 33 bit scale
// multipliers, and the result register that floors and saturates the
// coordinates, joins the row to the previous one and tracks the trace
// column. A new sample is accepted every cycle while results are taken. A
// result that is not taken holds the result register; the stages behind it
// still accept samples until all three are full, and then the input stalls.
// A first sample whose point count exceeds the limit rejects its trace: it
// and the samples after it report an error with nothing to paint until the
// next first sample. Configuration registers are to be written only while
// the block is idle; the block itself does not enforce this.
module trace_column_span_rasterizer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcsr_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_first,
  input  logic signed [tcsr_pkg::DATA_W-1:0]  in_x_sample,
  input  logic signed [tcsr_pkg::DATA_W-1:0]  in_y_sample,
  input  logic [tcsr_pkg::COUNT_W-1:0]        in_point_count,
  input  logic [tcsr_pkg::COLOR_W-1:0]        in_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tcsr_pkg::OUT_W-1:0]   out_column,
  output logic signed [tcsr_pkg::OUT_W-1:0]   out_row_low,
  output logic signed [tcsr_pkg::OUT_W-1:0]   out_row_high,
  output logic [tcsr_pkg::COLOR_W-1:0]        out_paint_color,
  output logic                                out_error
);
  import tcsr_pkg::*;

  cfg_t cfg;
  logic s1_valid;
  logic s1_ready;
  s1_t  s1;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2;

  tcsr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  tcsr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_i          (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first       (in_first),
    .in_x_sample    (in_x_sample),
    .in_y_sample    (in_y_sample),
    .in_point_count (in_point_count),
    .in_color       (in_color),
    .s1_valid_o     (s1_valid),
    .s1_o           (s1),
    .s1_ready_i     (s1_ready)
  );

  tcsr_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .s1_ready_o (s1_ready),
    .s2_valid_o (s2_valid),
    .s2_o       (s2),
    .s2_ready_i (s2_ready)
  );

  tcsr_span u_span (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_i           (cfg),
    .s2_valid_i      (s2_valid),
    .s2_i            (s2),
    .s2_ready_o      (s2_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_row_low     (out_row_low),
    .out_row_high    (out_row_high),
    .out_paint_color (out_paint_color),
    .out_error       (out_error)
  );

endmodule
